[design/convex_hull_gift_wrapping_macros.svh]
// assertion helpers for the top-level design file
`ifndef CONVEX_HULL_GIFT_WRAPPING_MACROS_SVH
`define CONVEX_HULL_GIFT_WRAPPING_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CHGW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CHGW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/chgw_pkg.sv]
package chgw_pkg;

    // default sizes
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 16;

    // comparison counter, saturating
    localparam int                    COUNT_BITS = 13;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // turn direction codes
    typedef enum logic [1:0] {
        COLLINEAR        = 2'd0,
        CLOCKWISE        = 2'd1,
        COUNTERCLOCKWISE = 2'd2
    } t_orient;

    // controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_EMPTY,
        ST_MIN_RD,
        ST_MIN_CMP,
        ST_WALK,
        ST_SC_RD,
        ST_SC_DIFF,
        ST_SC_MUL,
        ST_SC_DEC,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // store the incoming point
        logic min_start;   // clear scan index and comparison count
        logic min_upd;     // leftmost search step
        logic walk_start;  // first hull vertex from leftmost point
        logic diff;        // form edge vectors
        logic mul;         // cross product terms
        logic dec;         // turn decision, candidate update
        logic emit;        // put current vertex into output register
        logic emit_empty;  // put the empty marker into output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic few;         // fewer than three points stored
        logic idx_last;    // scan index at last stored point
        logic walk_done;   // this vertex closes or cuts off the walk
        logic out_free;    // output register can take an item
    } t_sts;

endpackage

[design/convex_hull_gift_wrapping.sv]
// loading: one point per cycle, n points stored, extras beyond MAX_POINTS dropped
// after the last point: a check state, then a leftmost search that reads and compares each point,
// then per hull vertex a decision loop per point (store read, edge vectors, cross product, turn
// decision) and an emit; results leave one a vertex
// no new point is taken until the last vertex is in the output register
// synchronous active-low reset empties the point store count and the output register
`include "convex_hull_gift_wrapping_macros.svh"

module convex_hull_gift_wrapping #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF,
    localparam int DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int USER_W    = 2 + chgw_pkg::COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // point_x, point_y, zero fill
    input  logic              s_axis_tlast,   // last_point
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // hull_x, hull_y, zero fill
    output logic [USER_W-1:0] m_axis_tuser,   // hull_empty, wrap_overflow, compare_count
    output logic              m_axis_tlast    // last_vertex
);

    chgw_pkg::t_cmd cmd;
    chgw_pkg::t_sts sts;

    logic signed [COORD_BITS-1:0]    hull_x, hull_y;
    logic                            hull_empty, wrap_overflow;
    logic [chgw_pkg::COUNT_BITS-1:0] compare_count;

    // sequencer
    chgw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // point store, orientation unit, output register
    chgw_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_point_x       (s_axis_tdata[COORD_BITS-1:0]),
        .i_point_y       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_out_ready     (m_axis_tready),
        .o_sts           (sts),
        .o_out_valid     (m_axis_tvalid),
        .o_hull_x        (hull_x),
        .o_hull_y        (hull_y),
        .o_hull_empty    (hull_empty),
        .o_wrap_overflow (wrap_overflow),
        .o_compare_count (compare_count),
        .o_last_vertex   (m_axis_tlast)
    );

    // result packing
    assign m_axis_tdata = DATA_W'({hull_y, hull_x});
    assign m_axis_tuser = {compare_count, wrap_overflow, hull_empty};

    // checks
    `CHGW_ASSERT_IMP(a_empty_alone,
        m_axis_tvalid && hull_empty,
        m_axis_tlast && (compare_count == '0) && !wrap_overflow,
        "empty result not a lone final item")
    `CHGW_ASSERT_IMP(a_count_on_last,
        m_axis_tvalid && !m_axis_tlast,
        (compare_count == '0) && !wrap_overflow,
        "count or overflow flag before final vertex")
    `CHGW_ASSERT_NXT(a_busy_after_last,
        s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready,
        "point taken right after a closing point")
    `CHGW_ASSERT_IMP(a_vertex_count,
        m_axis_tvalid && m_axis_tlast && !hull_empty,
        compare_count != '0,
        "hull closed without orientation tests")

endmodule

[design/chgw_ctrl.sv]
module chgw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  chgw_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output chgw_pkg::t_cmd o_cmd
);

    chgw_pkg::t_state r_state;
    chgw_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chgw_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chgw_pkg::ST_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = chgw_pkg::ST_CHECK;
                end
            end
            chgw_pkg::ST_CHECK: begin
                n_state = i_sts.few ? chgw_pkg::ST_EMPTY : chgw_pkg::ST_MIN_RD;
            end
            chgw_pkg::ST_EMPTY: begin
                if (i_sts.out_free) begin
                    n_state = chgw_pkg::ST_LOAD;
                end
            end
            chgw_pkg::ST_MIN_RD:  n_state = chgw_pkg::ST_MIN_CMP;
            chgw_pkg::ST_MIN_CMP: begin
                n_state = i_sts.idx_last ? chgw_pkg::ST_WALK : chgw_pkg::ST_MIN_RD;
            end
            chgw_pkg::ST_WALK:    n_state = chgw_pkg::ST_SC_RD;
            chgw_pkg::ST_SC_RD:   n_state = chgw_pkg::ST_SC_DIFF;
            chgw_pkg::ST_SC_DIFF: n_state = chgw_pkg::ST_SC_MUL;
            chgw_pkg::ST_SC_MUL:  n_state = chgw_pkg::ST_SC_DEC;
            chgw_pkg::ST_SC_DEC: begin
                n_state = i_sts.idx_last ? chgw_pkg::ST_EMIT : chgw_pkg::ST_SC_RD;
            end
            chgw_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.walk_done ? chgw_pkg::ST_LOAD : chgw_pkg::ST_SC_RD;
                end
            end
            default: n_state = chgw_pkg::ST_LOAD;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            chgw_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            chgw_pkg::ST_CHECK:   o_cmd.min_start  = 1'b1;
            chgw_pkg::ST_EMPTY:   o_cmd.emit_empty = i_sts.out_free;
            chgw_pkg::ST_MIN_RD:  o_cmd            = '0;
            chgw_pkg::ST_MIN_CMP: o_cmd.min_upd    = 1'b1;
            chgw_pkg::ST_WALK:    o_cmd.walk_start = 1'b1;
            chgw_pkg::ST_SC_RD:   o_cmd            = '0;
            chgw_pkg::ST_SC_DIFF: o_cmd.diff       = 1'b1;
            chgw_pkg::ST_SC_MUL:  o_cmd.mul        = 1'b1;
            chgw_pkg::ST_SC_DEC:  o_cmd.dec        = 1'b1;
            chgw_pkg::ST_EMIT:    o_cmd.emit       = i_sts.out_free;
            default:              o_cmd            = '0;
        endcase
    end

endmodule

[design/chgw_dp.sv]
module chgw_dp #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  chgw_pkg::t_cmd                  i_cmd,
    input  logic signed [COORD_BITS-1:0]    i_point_x,
    input  logic signed [COORD_BITS-1:0]    i_point_y,
    input  logic                            i_out_ready,
    output chgw_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    output logic signed [COORD_BITS-1:0]    o_hull_x,
    output logic signed [COORD_BITS-1:0]    o_hull_y,
    output logic                            o_hull_empty,
    output logic                            o_wrap_overflow,
    output logic [chgw_pkg::COUNT_BITS-1:0] o_compare_count,
    output logic                            o_last_vertex
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int NB = $clog2(MAX_POINTS + 1);
    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    // point store, x in the low half
    logic [2*CW-1:0] r_pts_mem [MAX_POINTS];

    logic [NB-1:0]                    r_n;
    logic [IW-1:0]                    r_i;
    logic [NB-1:0]                    r_k;
    logic [chgw_pkg::COUNT_BITS-1:0]  r_count;
    logic signed [CW-1:0]             r_rd_x, r_rd_y;
    logic [IW-1:0]                    r_best_idx;
    logic signed [CW-1:0]             r_best_x, r_best_y;
    logic [IW-1:0]                    r_start_idx;
    logic [IW-1:0]                    r_cur_idx;
    logic signed [CW-1:0]             r_cur_x, r_cur_y;
    logic [IW-1:0]                    r_cand_idx;
    logic signed [CW-1:0]             r_cand_x, r_cand_y;
    logic signed [DW-1:0]             r_ax, r_ay, r_bx, r_by;
    logic signed [PW-1:0]             r_p1, r_p2;
    logic                             r_out_valid;
    logic signed [CW-1:0]             r_out_x, r_out_y;
    logic                             r_out_empty, r_out_ovf, r_out_last;
    logic [chgw_pkg::COUNT_BITS-1:0]  r_out_count;

    logic                 store_room;
    logic                 idx_last;
    logic                 k_full;
    logic                 closes;
    logic                 walk_done;
    logic                 out_free;
    logic                 finish;
    logic                 better;
    logic                 take;
    logic signed [XW-1:0] xprod;
    chgw_pkg::t_orient    orient;

    // status
    assign store_room = (r_n < NB'(MAX_POINTS));
    assign idx_last   = (NB'(r_i) == (r_n - NB'(1)));
    assign k_full     = ((r_k + NB'(1)) >= r_n);
    assign closes     = (r_cand_idx == r_start_idx);
    assign walk_done  = closes || k_full;
    assign out_free   = !r_out_valid || i_out_ready;
    assign finish     = i_cmd.emit_empty || (i_cmd.emit && walk_done);

    always_comb begin
        o_sts           = '0;
        o_sts.few       = (r_n < NB'(3));
        o_sts.idx_last  = idx_last;
        o_sts.walk_done = walk_done;
        o_sts.out_free  = out_free;
    end

    // leftmost test, lowest on an x tie, earliest on a full tie
    assign better = (r_i == '0) || (r_rd_x < r_best_x) ||
                    ((r_rd_x == r_best_x) && (r_rd_y < r_best_y));

    // sign of the cross product decides the turn
    assign xprod = {r_p1[PW-1], r_p1} - {r_p2[PW-1], r_p2};

    always_comb begin
        if (xprod[XW-1]) begin
            orient = chgw_pkg::COUNTERCLOCKWISE;
        end else if (xprod != '0) begin
            orient = chgw_pkg::CLOCKWISE;
        end else begin
            orient = chgw_pkg::COLLINEAR;
        end
    end

    assign take = (r_i == '0) || (r_cand_idx == r_cur_idx) ||
                  (orient == chgw_pkg::COUNTERCLOCKWISE);

    // point store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && store_room) begin
            r_pts_mem[r_n[IW-1:0]] <= {i_point_y, i_point_x};
        end
        {r_rd_y, r_rd_x} <= r_pts_mem[r_i];
    end

    // point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (finish) begin
            r_n <= '0;
        end else if (i_cmd.load && store_room) begin
            r_n <= r_n + NB'(1);
        end
    end

    // scan index, vertex count, comparison count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_k     <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.min_start) begin
                r_i     <= '0;
                r_count <= '0;
            end
            if (i_cmd.min_upd && !idx_last) begin
                r_i <= r_i + IW'(1);
            end
            if (i_cmd.walk_start) begin
                r_i <= '0;
                r_k <= '0;
            end
            if (i_cmd.dec) begin
                if (!idx_last) begin
                    r_i <= r_i + IW'(1);
                end
                if (r_count != chgw_pkg::COUNT_MAX) begin
                    r_count <= r_count + chgw_pkg::COUNT_BITS'(1);
                end
            end
            if (i_cmd.emit) begin
                r_i <= '0;
                r_k <= r_k + NB'(1);
            end
        end
    end

    // leftmost point, current vertex and candidate
    always_ff @(posedge i_clk) begin
        if (i_cmd.min_upd && better) begin
            r_best_idx <= r_i;
            r_best_x   <= r_rd_x;
            r_best_y   <= r_rd_y;
        end
        if (i_cmd.walk_start) begin
            r_start_idx <= r_best_idx;
            r_cur_idx   <= r_best_idx;
            r_cur_x     <= r_best_x;
            r_cur_y     <= r_best_y;
        end
        if (i_cmd.dec && take) begin
            r_cand_idx <= r_i;
            r_cand_x   <= r_rd_x;
            r_cand_y   <= r_rd_y;
        end
        if (i_cmd.emit) begin
            r_cur_idx <= r_cand_idx;
            r_cur_x   <= r_cand_x;
            r_cur_y   <= r_cand_y;
        end
    end

    // edge vectors and cross product terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_ax <= {r_cand_x[CW-1], r_cand_x} - {r_cur_x[CW-1], r_cur_x};
            r_ay <= {r_cand_y[CW-1], r_cand_y} - {r_cur_y[CW-1], r_cur_y};
            r_bx <= {r_rd_x[CW-1], r_rd_x} - {r_cur_x[CW-1], r_cur_x};
            r_by <= {r_rd_y[CW-1], r_rd_y} - {r_cur_y[CW-1], r_cur_y};
        end
        if (i_cmd.mul) begin
            r_p1 <= r_ax * r_by;
            r_p2 <= r_ay * r_bx;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_empty <= 1'b1;
            r_out_ovf   <= 1'b0;
            r_out_count <= '0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_empty <= 1'b0;
            r_out_ovf   <= !closes && k_full;
            r_out_count <= walk_done ? r_count : '0;
            r_out_last  <= walk_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hull_x        = r_out_x;
    assign o_hull_y        = r_out_y;
    assign o_hull_empty    = r_out_empty;
    assign o_wrap_overflow = r_out_ovf;
    assign o_compare_count = r_out_count;
    assign o_last_vertex   = r_out_last;

endmodule

[tb/tb_convex_hull_gift_wrapping.sv]
`timescale 1ns / 100ps

module tb_convex_hull_gift_wrapping;

    localparam int NPTS   = chgw_pkg::MAX_POINTS_DEF;
    localparam int DATA_W = 32;
    localparam int USER_W = 2 + chgw_pkg::COUNT_BITS;
    localparam int ITEMS  = 270;

    // one hull vertex as it should leave the block
    typedef struct {
        logic signed [15:0]            x;
        logic signed [15:0]            y;
        bit                            empty;
        bit                            ovf;
        bit [chgw_pkg::COUNT_BITS-1:0] count;
        bit                            last;
    } t_hull_vertex;

    // how the points of a set are drawn
    typedef enum int {
        PTS_WIDE,
        PTS_GRID,
        PTS_MID,
        PTS_ARC
    } t_point_style;

    // point store mirror, gift wrapping prediction and vertex checking
    class hull_scoreboard;
        logic signed [15:0] px[NPTS];
        logic signed [15:0] py[NPTS];
        int                 loaded;
        t_hull_vertex       expected_vertices[$];
        int                 errors;

        function new();
            loaded = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction

        // turn from point f over point m to point l
        function chgw_pkg::t_orient turn_of(int f, int m, int l);
            longint ax, ay, bx, by, c;
            ax = longint'(px[f]) - longint'(px[m]);
            ay = longint'(py[f]) - longint'(py[m]);
            bx = longint'(px[l]) - longint'(px[m]);
            by = longint'(py[l]) - longint'(py[m]);
            c  = ax * by - ay * bx;
            if (c > 0) return chgw_pkg::CLOCKWISE;
            if (c < 0) return chgw_pkg::COUNTERCLOCKWISE;
            if (f != m) return chgw_pkg::COLLINEAR;
            // same first and middle point: slope sign decides
            if (bx == 0) begin
                if (by < 0) return chgw_pkg::COUNTERCLOCKWISE;
                if (by == 0) return chgw_pkg::COLLINEAR;
                return chgw_pkg::CLOCKWISE;
            end
            if (by == 0 || ((by > 0) == (bx > 0))) return chgw_pkg::COUNTERCLOCKWISE;
            return chgw_pkg::CLOCKWISE;
        endfunction

        // walk the hull of the n stored points and queue its vertices
        function void wrap_hull(int n);
            t_hull_vertex v;
            int           first, cur, cand, emitted, steps;
            bit           cut;
            if (n < 3) begin
                v = '{x: 0, y: 0, empty: 1, ovf: 0, count: 0, last: 1};
                expected_vertices.push_back(v);
                return;
            end
            // leftmost, then lowest, then earliest
            first = 0;
            for (int i = 1; i < n; i++) begin
                if (px[i] < px[first] || (px[i] == px[first] && py[i] < py[first]))
                    first = i;
            end
            cur     = first;
            emitted = 0;
            steps   = 0;
            cut     = 0;
            forever begin
                v = '{x: px[cur], y: py[cur], empty: 0, ovf: 0, count: 0, last: 0};
                expected_vertices.push_back(v);
                emitted++;
                cand = 0;
                for (int i = 0; i < n; i++) begin
                    if (cand == cur || turn_of(cand, cur, i) == chgw_pkg::COUNTERCLOCKWISE)
                        cand = i;
                    if (steps < int'(chgw_pkg::COUNT_MAX))
                        steps++;
                end
                cur = cand;
                if (cur == first) break;
                if (emitted >= n) begin
                    cut = 1;
                    break;
                end
            end
            // closing vertex carries the flags and the count
            v       = expected_vertices.pop_back();
            v.ovf   = cut;
            v.count = steps[chgw_pkg::COUNT_BITS-1:0];
            v.last  = 1;
            expected_vertices.push_back(v);
        endfunction

        // accepted input point
        function void note_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
            int n;
            if (loaded < NPTS) begin
                px[loaded] = x;
                py[loaded] = y;
                loaded++;
            end
            if (last) begin
                n      = loaded;
                loaded = 0;
                wrap_hull(n);
            end
        endfunction

        // accepted output vertex against the oldest expectation
        function void check_vertex(logic [DATA_W-1:0] data, logic [USER_W-1:0] user,
                                   logic last);
            t_hull_vertex       exp_v;
            logic signed [15:0] got_x, got_y;
            got_x = data[15:0];
            got_y = data[31:16];
            if (expected_vertices.size() == 0) begin
                $error("unexpected hull vertex x=%0d y=%0d", got_x, got_y);
                errors++;
                return;
            end
            exp_v = expected_vertices.pop_front();
            if (got_x !== exp_v.x) begin
                $error("hull_x expected %0d got %0d", exp_v.x, got_x);
                errors++;
            end
            if (got_y !== exp_v.y) begin
                $error("hull_y expected %0d got %0d", exp_v.y, got_y);
                errors++;
            end
            if (user[0] !== exp_v.empty) begin
                $error("hull_empty expected %0d got %0d", exp_v.empty, user[0]);
                errors++;
            end
            if (user[1] !== exp_v.ovf) begin
                $error("wrap_overflow expected %0d got %0d", exp_v.ovf, user[1]);
                errors++;
            end
            if (user[USER_W-1:2] !== exp_v.count) begin
                $error("compare_count expected %0d got %0d", exp_v.count,
                       user[USER_W-1:2]);
                errors++;
            end
            if (last !== exp_v.last) begin
                $error("last_vertex expected %0d got %0d", exp_v.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // point_x, point_y
    logic              s_axis_tlast;   // last_point
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // hull_x, hull_y
    logic [USER_W-1:0] m_axis_tuser;   // hull_empty, wrap_overflow, compare_count
    logic              m_axis_tlast;   // last_vertex

    hull_scoreboard hull_sb;
    int             points_sent;
    int             rdy_left;
    int             stall_left;

    convex_hull_gift_wrapping dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one point on the input stream, after an optional idle gap
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input bit last, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        points_sent++;
    endtask

    // hold the input until every queued vertex has left
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hull_sb.pending() != 0) @(posedge i_clk);
    endtask

    // one point set, last marker on its final point
    task automatic send_set(input int count, input t_point_style style);
        int                 bx, by, rot, idx, quiet;
        logic signed [15:0] x, y;
        bx    = int'($urandom_range(0, 65535 - 80)) - 32768;
        by    = int'($urandom_range(0, 65535 - 1400)) - 32768;
        rot   = $urandom_range(0, 127);
        quiet = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            case (style)
                PTS_WIDE: begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                end
                PTS_GRID: begin
                    x = 16'(int'($urandom_range(0, 8)) - 4);
                    y = 16'(int'($urandom_range(0, 8)) - 4);
                end
                PTS_MID: begin
                    x = 16'(int'($urandom_range(0, 2000)) - 1000);
                    y = 16'(int'($urandom_range(0, 2000)) - 1000);
                end
                default: begin
                    // points on a parabola, all of them hull vertices
                    idx = (k + rot) % count;
                    x   = 16'(bx + idx);
                    y   = 16'(by + (idx - count / 2) * (idx - count / 2));
                end
            endcase
            send_point(x, y, k == count - 1, quiet ? 0 : gap_len());
        end
    endtask

    // receiver: random stalls between ready stretches
    always @(posedge i_clk) begin
        if (rdy_left > 0) begin
            m_axis_tready <= 1'b1;
            rdy_left--;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = gap_len();
            rdy_left   = $urandom_range(1, 30);
        end
    end

    // accepted items on both streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                hull_sb.check_vertex(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                hull_sb.note_point(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
        end
    end

    // stimulus and end of run
    initial begin
        int dir_x[23];
        int dir_y[23];
        bit dir_last[23];
        int r, cnt;
        t_point_style style;

        hull_sb     = new();
        points_sent = 0;
        rdy_left    = 0;
        stall_left  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;

        // single point, two points, extreme triangle, square with an x tie,
        // duplicated start with collinear points, all coincident, vertical line
        dir_x    = '{-32768, 32767, 0, -32768, 32767, 0, 5, -5, -5, 5, 0, 0,
                     0, 0, 4, 2, 4, 7, 7, 7, 1, 1, 1};
        dir_y    = '{32767, -32768, 0, -32768, -32768, 32767, 5, 5, -5, -5, 0, -5,
                     0, 0, 4, 2, 0, 7, 7, 7, 1, 3, 2};
        dir_last = '{1, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1,
                     0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 1};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed sets
        for (int i = 0; i < 23; i++)
            send_point(16'(dir_x[i]), 16'(dir_y[i]), dir_last[i], gap_len());
        wait_drained();

        // largest hull, then a set overrunning the store
        send_set(NPTS, PTS_ARC);
        send_set(NPTS + 6, PTS_WIDE);

        // random sets
        while (points_sent < ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) cnt = $urandom_range(1, 2);
            else if (r < 80) cnt = $urandom_range(3, 12);
            else if (r < 96) cnt = $urandom_range(13, 30);
            else cnt = $urandom_range(40, NPTS + 4);
            r = $urandom_range(0, 99);
            if (r < 35) style = PTS_WIDE;
            else if (r < 65) style = PTS_GRID;
            else if (r < 90) style = PTS_MID;
            else style = PTS_ARC;
            send_set(cnt, style);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        // drain and settle
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (hull_sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/chgw_pkg.sv
design/chgw_ctrl.sv
design/chgw_dp.sv
design/convex_hull_gift_wrapping.sv
tb/tb_convex_hull_gift_wrapping.sv
